// File: rtl/bgpa_pkg.sv
// Shared types, constants and a helper function for the bitmap graphics port.
package bgpa_pkg;

   localparam int COORD_BITS = 8;
   localparam int ADDR_BITS  = 2 * COORD_BITS;
   localparam int CELLS      = 1 << ADDR_BITS;

   localparam int REQ_DATA_BITS = 16;
   localparam int RSP_DATA_BITS = 24;

   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_CTRL  = 2'd2;

   localparam logic [2:0] OFFS_LOAD_X = 3'd3;
   localparam logic [2:0] OFFS_LOAD_Y = 3'd7;

   localparam logic [2:0] STEP_DL = 3'd0;
   localparam logic [2:0] STEP_U  = 3'd1;
   localparam logic [2:0] STEP_L  = 3'd2;
   localparam logic [2:0] STEP_DR = 3'd4;
   localparam logic [2:0] STEP_D  = 3'd5;
   localparam logic [2:0] STEP_R  = 3'd6;

   localparam logic [3:0] PIXEL_MASK = 4'hf;

   typedef logic [COORD_BITS-1:0] coord_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ
   } state_type;

   typedef struct packed {
      logic exec;       // execute the transfer presented on the request side
      logic clr_en;     // write one zero entry of the clearing sweep
      logic load_read;  // load the registered read pixel into the response
   } cmd_type;

   typedef struct packed {
      logic item_read;
      logic item_clears;
      logic clear_last;
      logic out_free;
   } status_type;

   // Returns the X delta in the upper half and the Y delta in the lower half.
   function automatic logic [2*COORD_BITS-1:0] step_delta(input logic [2:0] code);
      coord_type dx;
      coord_type dy;
      dx = '0;
      dy = '0;
      case (code)
         STEP_DL: begin
            dx = '1;
            dy = COORD_BITS'(1);
         end
         STEP_U: dy = '1;
         STEP_L: dx = '1;
         STEP_DR: begin
            dx = COORD_BITS'(1);
            dy = COORD_BITS'(1);
         end
         STEP_D: dy = COORD_BITS'(1);
         STEP_R: dx = COORD_BITS'(1);
         default: begin
            dx = '0;
            dy = '0;
         end
      endcase
      return {dx, dy};
   endfunction

endpackage

// File: rtl/bitmap_graphics_port_autostep.sv
// A port or control write shows its result the cycle after the transfer;
// a pixel read is registered at the bitmap read port, then in the response register.
// Reads stall requests until loaded; pixel writes go every cycle while results drain.
// A clear walks all 65536 cells of the written bitmap, one a cycle, inputs held off.
// Reset (synchronous, active high) zeroes X, Y and the select bit and then clears
// both bitmaps in one sweep over all 65536 cells before the first request is taken.
module bitmap_graphics_port_autostep (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // [1:0] action, [4:2] port_offset, [12:5] write_value, [15:13] zero
   input  logic [bgpa_pkg::REQ_DATA_BITS-1:0] req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] pixel_out, [11:4] x_now, [19:12] y_now, [23:20] zero
   output logic [bgpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import bgpa_pkg::*;

   cmd_type    cmd;
   status_type status;

   bgpa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bgpa_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .action      (req_tdata[1:0]),
      .port_offset (req_tdata[4:2]),
      .write_value (req_tdata[12:5]),
      .cmd         (cmd),
      .status      (status),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

// File: rtl/bgpa_ctrl.sv
// Controller state machine that sequences transfers, reads and clearing sweeps.
module bgpa_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  bgpa_pkg::status_type status,
   output bgpa_pkg::cmd_type    cmd
);
   import bgpa_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = status.out_free;
            if (req_tvalid && status.out_free) begin
               cmd.exec = 1'b1;
               if (status.item_read) begin
                  state_in = ST_READ;
               end else if (status.item_clears) begin
                  state_in = ST_CLEAR;
               end
            end
         end
         ST_READ: begin
            // Hold the read pixel until the response register can take it.
            if (status.out_free) begin
               cmd.load_read = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// File: rtl/bgpa_datapath.sv
// Datapath: address registers, buffer select, both bitmaps, clear counter and response register.
module bgpa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic [1:0]                         action,
   input  logic [2:0]                         port_offset,
   input  logic [7:0]                         write_value,
   input  bgpa_pkg::cmd_type                  cmd,
   output bgpa_pkg::status_type               status,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [bgpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import bgpa_pkg::*;

   logic [3:0] bitmap_a_ff [CELLS];
   logic [3:0] bitmap_b_ff [CELLS];

   coord_type            x_ff, x_in;
   coord_type            y_ff, y_in;
   logic                 sel_ff, sel_in;
   logic                 clr_a_ff, clr_a_in;
   logic                 clr_b_ff, clr_b_in;
   logic [ADDR_BITS-1:0] clr_cnt_ff, clr_cnt_in;
   logic [3:0]           rd_a_ff, rd_b_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [3:0]           out_pixel_ff, out_pixel_in;
   logic [7:0]           out_x_ff, out_x_in;
   logic [7:0]           out_y_ff, out_y_in;

   logic [2*COORD_BITS-1:0] delta;
   logic [ADDR_BITS-1:0]    cell_addr;
   logic [ADDR_BITS-1:0]    wr_addr;
   logic [3:0]              wr_data;
   logic                    pix_write;
   logic                    rd_en;
   logic                    wr_a;
   logic                    wr_b;
   logic                    out_free;

   assign delta     = step_delta(port_offset);
   assign cell_addr = {y_ff, x_ff};
   assign out_free  = !out_valid_ff || rsp_tready;

   assign rd_en     = cmd.exec && (action == ACT_READ);
   assign pix_write = cmd.exec && (action == ACT_WRITE) &&
                      (port_offset != OFFS_LOAD_X) && (port_offset != OFFS_LOAD_Y);

   assign wr_addr = cmd.clr_en ? clr_cnt_ff : cell_addr;
   assign wr_data = cmd.clr_en ? 4'h0 : (write_value[3:0] & PIXEL_MASK);
   // Pixel writes and clears go to buffer A when the select bit is set; reads take B.
   assign wr_a    = (pix_write && sel_ff) || (cmd.clr_en && clr_a_ff);
   assign wr_b    = (pix_write && !sel_ff) || (cmd.clr_en && clr_b_ff);

   always_ff @(posedge clock) begin
      if (wr_a) begin
         bitmap_a_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= bitmap_a_ff[cell_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_b) begin
         bitmap_b_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_b_ff <= bitmap_b_ff[cell_addr];
      end
   end

   always_comb begin
      x_in       = x_ff;
      y_in       = y_ff;
      sel_in     = sel_ff;
      clr_a_in   = clr_a_ff;
      clr_b_in   = clr_b_ff;
      clr_cnt_in = cmd.clr_en ? clr_cnt_ff + 1'b1 : clr_cnt_ff;
      if (cmd.exec) begin
         case (action)
            ACT_READ: begin
               x_in = x_ff + delta[2*COORD_BITS-1:COORD_BITS];
               y_in = y_ff + delta[COORD_BITS-1:0];
            end
            ACT_WRITE: begin
               if (port_offset == OFFS_LOAD_X) begin
                  x_in = COORD_BITS'(write_value);
               end else if (port_offset == OFFS_LOAD_Y) begin
                  y_in = COORD_BITS'(write_value);
               end else begin
                  x_in = x_ff + delta[2*COORD_BITS-1:COORD_BITS];
                  y_in = y_ff + delta[COORD_BITS-1:0];
               end
            end
            ACT_CTRL: begin
               sel_in = write_value[0];
               if (write_value[1]) begin
                  clr_a_in   = write_value[0];
                  clr_b_in   = !write_value[0];
                  clr_cnt_in = '0;
               end
            end
            default: begin
               x_in = x_ff;
            end
         endcase
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_tready;
      out_pixel_in = out_pixel_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      if (cmd.exec && (action != ACT_READ)) begin
         out_valid_in = 1'b1;
         out_pixel_in = 4'h0;
         out_x_in     = 8'(x_in);
         out_y_in     = 8'(y_in);
      end else if (cmd.load_read) begin
         out_valid_in = 1'b1;
         out_pixel_in = sel_ff ? rd_b_ff : rd_a_ff;
         out_x_in     = 8'(x_ff);
         out_y_in     = 8'(y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff         <= '0;
         y_ff         <= '0;
         sel_ff       <= 1'b0;
         clr_a_ff     <= 1'b1;
         clr_b_ff     <= 1'b1;
         clr_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         x_ff         <= x_in;
         y_ff         <= y_in;
         sel_ff       <= sel_in;
         clr_a_ff     <= clr_a_in;
         clr_b_ff     <= clr_b_in;
         clr_cnt_ff   <= clr_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_pixel_ff <= out_pixel_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
   end

   assign status.item_read   = (action == ACT_READ);
   assign status.item_clears = (action == ACT_CTRL) && write_value[1];
   assign status.clear_last  = (clr_cnt_ff == {ADDR_BITS{1'b1}});
   assign status.out_free    = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'h0, out_y_ff, out_x_ff, out_pixel_ff};

endmodule

// File: rtl/bgpa_checker.sv
// Port-level checker for the bitmap graphics port and its bind statement.
module bgpa_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [bgpa_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [bgpa_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import bgpa_pkg::*;

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The bitmaps are being cleared right after reset, so no request is taken.
   assert property (@(posedge clock) reset |=> !req_tready)
      else $error("request taken during the reset clear");

   // A request transfer never overruns a response that is still waiting.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request accepted over a pending response");

   // A load of X reports the loaded value in the next response.
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tdata[1:0] == ACT_WRITE) &&
      (req_tdata[4:2] == OFFS_LOAD_X)
      |=> rsp_tvalid && (rsp_tdata[11:4] == $past(req_tdata[12:5])))
      else $error("X load not reflected in the response");

endmodule

bind bitmap_graphics_port_autostep bgpa_checker u_bgpa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
